// ----- rtl/ncl_pkg.sv -----
package ncl_pkg;

  localparam int DEF_MAX_CLUSTERS = 16;
  localparam int DEF_MAX_FEATURES = 16;

  localparam int VALUE_W = 16;
  localparam int INDEX_W = 4;
  localparam int LABEL_W = 4;
  localparam int DIST_W  = 36;
  localparam int CFG_W   = 5;
  localparam int ABS_W   = 16;
  localparam int SQ_W    = 2 * ABS_W;

  localparam logic [DIST_W-1:0] DIST_MAX  = '1;
  localparam logic [CFG_W-1:0]  CFG_RESET = 5'd16;

  localparam logic FUNC_TABLE   = 1'b0;
  localparam logic FUNC_FEATURE = 1'b1;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FLUSH,
    ST_SWEEP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                       tbl_wr;
    logic                       feat_rd;
    logic [INDEX_W-1:0]         cluster_index;
    logic [INDEX_W-1:0]         feature_index;
    logic signed [VALUE_W-1:0]  wr_value;
    logic signed [VALUE_W-1:0]  s1_value;
    logic                       s3_add;
    logic                       clear;
  } cell_ctrl_t;

endpackage

// ----- rtl/ncl_in_if.sv -----
interface ncl_in_if;
  import ncl_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [INDEX_W-1:0]        cluster_index;
  logic [INDEX_W-1:0]        feature_index;
  logic signed [VALUE_W-1:0] value;
  logic                      last;

  modport source (
    output valid, func, cluster_index, feature_index, value, last,
    input  ready
  );

  modport sink (
    input  valid, func, cluster_index, feature_index, value, last,
    output ready
  );

endinterface

// ----- rtl/ncl_out_if.sv -----
interface ncl_out_if;
  import ncl_pkg::*;

  logic               valid;
  logic               ready;
  logic [LABEL_W-1:0] label;
  logic [DIST_W-1:0]  distance_sq;

  modport source (
    output valid, label, distance_sq,
    input  ready
  );

  modport sink (
    input  valid, label, distance_sq,
    output ready
  );

endinterface

// ----- rtl/ncl_cell.sv -----
module ncl_cell #(
  parameter int CELL_ID      = 0,
  parameter int MAX_FEATURES = ncl_pkg::DEF_MAX_FEATURES,
  parameter int IDX_W        = 4,
  parameter int CNT_W        = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ncl_pkg::cell_ctrl_t       ctrl,
  input  logic [CNT_W-1:0]          active,
  input  logic                      prev_valid,
  input  logic [IDX_W-1:0]          prev_idx,
  input  logic [ncl_pkg::DIST_W-1:0] prev_d,
  output logic                      cand_valid,
  output logic [IDX_W-1:0]          cand_idx,
  output logic [ncl_pkg::DIST_W-1:0] cand_d
);
  import ncl_pkg::*;

  localparam int FA_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

  logic signed [VALUE_W-1:0] mem [MAX_FEATURES];
  logic signed [VALUE_W-1:0] rd_q;
  logic [FA_W-1:0]           addr;
  logic                      own_wr;
  logic signed [VALUE_W:0]   diff;
  logic [ABS_W-1:0]          absd;
  logic [ABS_W-1:0]          absd_q;
  logic [SQ_W-1:0]           sq;
  logic [DIST_W-1:0]         acc;
  logic [DIST_W:0]           sum;
  logic                      take_own;

  assign addr   = FA_W'(ctrl.feature_index);
  assign own_wr = ctrl.tbl_wr && (int'(ctrl.cluster_index) == CELL_ID);

  always_ff @(posedge clk) begin
    if (own_wr) begin
      mem[addr] <= ctrl.wr_value;
    end
    if (ctrl.feat_rd) begin
      rd_q <= mem[addr];
    end
  end

  assign diff = (VALUE_W+1)'(rd_q) - (VALUE_W+1)'(ctrl.s1_value);
  assign absd = diff[VALUE_W] ? ABS_W'(-diff) : ABS_W'(diff);

  always_ff @(posedge clk) begin
    absd_q <= absd;
    sq     <= SQ_W'(absd_q * absd_q);
  end

  assign sum = {1'b0, acc} + (DIST_W+1)'(sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.s3_add) begin
      acc <= sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
    end
  end

  assign take_own = (CELL_ID == 0) ||
                    ((CNT_W'(CELL_ID) < active) && (acc < prev_d));

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_valid <= 1'b0;
    end else begin
      cand_valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prev_valid) begin
      if (take_own) begin
        cand_d   <= acc;
        cand_idx <= IDX_W'(CELL_ID);
      end else begin
        cand_d   <= prev_d;
        cand_idx <= prev_idx;
      end
    end
  end

endmodule

// ----- rtl/nearest_centroid_labeler.sv -----
// Channel  Dir  Payload                                              Moves when
// in_ch    in   func, cluster_index, feature_index, value, last      valid && ready
// out_ch   out  label, distance_sq                                   valid && ready
// cfg      in   cfg_data (clusters_in_use)                           cfg_we
//
// Table words and features are taken one per cycle, back to back within a point.
// After the item marked last, the pipeline drains through the difference,
// square and accumulate stages, then the best candidate walks the cell chain,
// one register per cell. The next item is taken once the result is loaded,
// which waits until the output register is free.
// Reset clears control state and accumulators; centroid words hold garbage
// until written. A result waits in the output register; input stalls from the
// last item of a point until its result is loaded.
module nearest_centroid_labeler #(
  parameter int MAX_CLUSTERS = ncl_pkg::DEF_MAX_CLUSTERS,
  parameter int MAX_FEATURES = ncl_pkg::DEF_MAX_FEATURES
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [ncl_pkg::CFG_W-1:0] cfg_data,
  ncl_in_if.sink                    in_ch,
  ncl_out_if.source                 out_ch
);
  import ncl_pkg::*;

  localparam int IDX_W = $clog2(MAX_CLUSTERS);
  localparam int CNT_W = $clog2(MAX_CLUSTERS + 1);

  logic [CFG_W-1:0]          clusters_in_use;
  logic [CNT_W-1:0]          active;
  state_t                    state;
  state_t                    state_next;
  logic                      in_ready;
  logic                      in_acc;
  logic                      feat_acc;
  logic                      fidx_ok;
  logic                      cidx_ok;
  logic                      load;
  logic                      s1_add;
  logic                      s1_last;
  logic signed [VALUE_W-1:0] s1_value;
  logic                      s2_add;
  logic                      s2_last;
  logic                      s3_add;
  logic                      s3_last;
  logic                      sweep_go;
  logic                      out_valid;
  logic [LABEL_W-1:0]        out_label;
  logic [DIST_W-1:0]         out_dist;
  cell_ctrl_t                ctrl;

  logic                      chain_valid [MAX_CLUSTERS+1];
  logic [IDX_W-1:0]          chain_idx   [MAX_CLUSTERS+1];
  logic [DIST_W-1:0]         chain_d     [MAX_CLUSTERS+1];

  assign in_ready = (state == ST_RUN);
  assign in_acc   = in_ch.valid && in_ready;
  assign feat_acc = in_acc && (in_ch.func == FUNC_FEATURE);
  assign fidx_ok  = int'(in_ch.feature_index) < MAX_FEATURES;
  assign cidx_ok  = int'(in_ch.cluster_index) < MAX_CLUSTERS;

  always_comb begin
    if (clusters_in_use == '0) begin
      active = CNT_W'(1);
    end else if (int'(clusters_in_use) > MAX_CLUSTERS) begin
      active = CNT_W'(MAX_CLUSTERS);
    end else begin
      active = CNT_W'(clusters_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clusters_in_use <= CFG_RESET;
    end else if (cfg_we) begin
      clusters_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load       = 1'b0;
    case (state)
      ST_RUN: begin
        if (in_ch.valid && (in_ch.func == FUNC_FEATURE) && in_ch.last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (s3_last) begin
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (chain_valid[MAX_CLUSTERS]) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || out_ch.ready) begin
          load       = 1'b1;
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_add   <= 1'b0;
      s1_last  <= 1'b0;
      s2_add   <= 1'b0;
      s2_last  <= 1'b0;
      s3_add   <= 1'b0;
      s3_last  <= 1'b0;
      sweep_go <= 1'b0;
    end else begin
      s1_add   <= feat_acc && fidx_ok;
      s1_last  <= feat_acc && in_ch.last;
      s2_add   <= s1_add;
      s2_last  <= s1_last;
      s3_add   <= s2_add;
      s3_last  <= s2_last;
      sweep_go <= (state == ST_FLUSH) && s3_last;
    end
  end

  always_ff @(posedge clk) begin
    s1_value <= in_ch.value;
  end

  always_comb begin
    ctrl.tbl_wr        = in_acc && (in_ch.func == FUNC_TABLE) && fidx_ok && cidx_ok;
    ctrl.feat_rd       = feat_acc && fidx_ok;
    ctrl.cluster_index = in_ch.cluster_index;
    ctrl.feature_index = in_ch.feature_index;
    ctrl.wr_value      = in_ch.value;
    ctrl.s1_value      = s1_value;
    ctrl.s3_add        = s3_add;
    ctrl.clear         = load;
  end

  assign chain_valid[0] = sweep_go;
  assign chain_idx[0]   = '0;
  assign chain_d[0]     = '0;

  for (genvar c = 0; c < MAX_CLUSTERS; c++) begin : g_cell
    ncl_cell #(
      .CELL_ID      (c),
      .MAX_FEATURES (MAX_FEATURES),
      .IDX_W        (IDX_W),
      .CNT_W        (CNT_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .active     (active),
      .prev_valid (chain_valid[c]),
      .prev_idx   (chain_idx[c]),
      .prev_d     (chain_d[c]),
      .cand_valid (chain_valid[c+1]),
      .cand_idx   (chain_idx[c+1]),
      .cand_d     (chain_d[c+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_label <= LABEL_W'(chain_idx[MAX_CLUSTERS]);
      out_dist  <= chain_d[MAX_CLUSTERS];
    end
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.label       = out_label;
  assign out_ch.distance_sq = out_dist;

  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    (feat_acc && in_ch.last) |=> !in_ch.ready)
    else $error("input still open after last feature");

  a_one_point: assert property (@(posedge clk) disable iff (rst)
    $onehot0({s1_last, s2_last, s3_last}))
    else $error("more than one point end in flight");

  a_tail_in_sweep: assert property (@(posedge clk) disable iff (rst)
    chain_valid[MAX_CLUSTERS] |-> (state == ST_SWEEP))
    else $error("chain result outside sweep");

  a_load_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> ($past(state) == ST_EMIT))
    else $error("result loaded outside emit");

endmodule
